[hdl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Command codes, error codes, fixed port widths and the per-beat shift control
// that the deque core sends down its row of storage cells.
// ----------------------------------------------------------------------------
package deq_pkg;

	// fixed port widths
	localparam int CMD_W  = 3;
	localparam int PORT_W = 32;
	localparam int POS_W  = 4;
	localparam int CNT_W  = 5;
	localparam int ERR_W  = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

	// error codes
	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;
	localparam logic [ERR_W-1:0] ERR_RANGE = 2'd3;

	// shift control broadcast to every cell
	typedef struct packed {
		logic shift_right;  // every cell takes its left neighbor
		logic load_back;    // cell at the fill count loads the new element
		logic shift_left;   // every cell takes its right neighbor
	} deq_ctrl_t;

endpackage

[hdl/deq_cell.sv]
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the deque row. Cell IDX holds the element at position
// IDX from the front and also reports itself as the back or the read target.
// ----------------------------------------------------------------------------
module deq_cell
	import deq_pkg::*;
#(
	parameter int IDX        = 0,
	parameter int DATA_WIDTH = 32,
	parameter int CW         = 5
) (
	input  logic                  clk,
	input  deq_ctrl_t             ctrl,
	input  logic [CW-1:0]         cnt,
	input  logic [POS_W-1:0]      pos,
	input  logic [DATA_WIDTH-1:0] push_data,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] back_tap,
	output logic [DATA_WIDTH-1:0] read_tap
);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] data_d;
	logic                  at_fill;
	logic                  is_back;
	logic                  is_read;

	assign at_fill = (32'(cnt) == 32'(IDX));
	assign is_back = (32'(cnt) == 32'(IDX + 1));
	assign is_read = (32'(pos) == 32'(IDX));

	// next content: shift along the row or load at the back
	always_comb begin
		data_d = data_q;
		if (ctrl.shift_right) begin
			data_d = left_data;
		end else if (ctrl.shift_left) begin
			data_d = right_data;
		end else if (ctrl.load_back && at_fill) begin
			data_d = push_data;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data     = data_q;
	assign back_tap = is_back ? data_q : '0;
	assign read_tap = is_read ? data_q : '0;

endmodule

[hdl/double_ended_queue_core.sv]
// Latency: a result beat is offered the cycle after its command beat is taken.
// Throughput: one command per cycle; the single result register is refilled in
// the same cycle it is drained, and only a stalled result holds off commands.
// Reset: arst_n clears the fill count and the result valid; cell contents are
// not reset and hold nothing meaningful until pushed.
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Fixed-capacity deque built as a row of shifting cells: position 0 is always
// the front, a push front shifts the row right, a pop front shifts it left.
// ----------------------------------------------------------------------------
module double_ended_queue_core
	import deq_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [PORT_W-1:0] value,
	input  logic [POS_W-1:0]  position,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [PORT_W-1:0] front_value,
	output logic [PORT_W-1:0] back_value,
	output logic [PORT_W-1:0] read_value,
	output logic [CNT_W-1:0]  count,
	output logic              is_empty,
	output logic              is_full,
	output logic [ERR_W-1:0]  error
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic                  accept;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         cnt_d;
	logic                  rsp_valid_q;
	logic [ERR_W-1:0]      err_q;
	logic [ERR_W-1:0]      err_d;
	logic                  rd_ok_q;
	logic                  rd_ok_d;
	logic [POS_W-1:0]      pos_q;
	logic                  full;
	logic                  empty;
	deq_ctrl_t             ctrl;
	logic [DATA_WIDTH-1:0] push_data;
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] back_tap  [CAPACITY];
	logic [DATA_WIDTH-1:0] read_tap  [CAPACITY];
	logic [DATA_WIDTH-1:0] back_sel;
	logic [DATA_WIDTH-1:0] read_sel;

	assign accept    = cmd_valid && cmd_ready;
	assign cmd_ready = !rsp_valid_q || rsp_ready;
	assign full      = (cnt_q == CW'(CAPACITY));
	assign empty     = (cnt_q == '0);
	assign push_data = DATA_WIDTH'(value);

	// command decode
	always_comb begin
		ctrl    = '0;
		cnt_d   = cnt_q;
		err_d   = ERR_OK;
		rd_ok_d = 1'b0;
		case (cmd)
			CMD_PUSH_BACK: begin
				if (full) begin
					err_d = ERR_FULL;
				end else begin
					ctrl.load_back = accept;
					cnt_d          = cnt_q + 1'b1;
				end
			end
			CMD_PUSH_FRONT: begin
				if (full) begin
					err_d = ERR_FULL;
				end else begin
					ctrl.shift_right = accept;
					cnt_d            = cnt_q + 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					err_d = ERR_EMPTY;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					err_d = ERR_EMPTY;
				end else begin
					ctrl.shift_left = accept;
					cnt_d           = cnt_q - 1'b1;
				end
			end
			CMD_READ: begin
				if (32'(position) >= 32'(cnt_q)) begin
					err_d = ERR_RANGE;
				end else begin
					rd_ok_d = 1'b1;
				end
			end
			CMD_CLEAR: begin
				cnt_d = '0;
			end
			default: begin
			end
		endcase
	end

	// fill count and result control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_d;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// per-beat result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q   <= err_d;
			rd_ok_q <= rd_ok_d;
			pos_q   <= position;
		end
	end

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = push_data;
		end else begin : g_mid
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_inner
			assign right_d = cell_data[i+1];
		end

		deq_cell #(
			.IDX        (i),
			.DATA_WIDTH (DATA_WIDTH),
			.CW         (CW)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.cnt        (cnt_q),
			.pos        (pos_q),
			.push_data  (push_data),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.back_tap   (back_tap[i]),
			.read_tap   (read_tap[i])
		);
	end

	// gather the back and read taps; at most one cell drives each
	always_comb begin
		back_sel = '0;
		read_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			back_sel = back_sel | back_tap[i];
			read_sel = read_sel | read_tap[i];
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign front_value = empty ? '0 : PORT_W'(cell_data[0]);
	assign back_value  = empty ? '0 : PORT_W'(back_sel);
	assign read_value  = rd_ok_q ? PORT_W'(read_sel) : '0;
	assign count       = CNT_W'(cnt_q);
	assign is_empty    = empty;
	assign is_full     = full;
	assign error       = err_q;

endmodule

[hdl/deq_checker.sv]
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks on the deque core's result beats, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker
	import deq_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [PORT_W-1:0] front_value,
	input logic [PORT_W-1:0] back_value,
	input logic [CNT_W-1:0]  count,
	input logic              is_empty,
	input logic              is_full,
	input logic [ERR_W-1:0]  error
);

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(count) && $stable(error))
		else $error("result beat changed while stalled");

	// empty flag agrees with the count
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && is_empty |-> count == '0 && !is_full)
		else $error("empty flag with nonzero count");

	// an empty queue shows zero at both ends
	a_empty_vals: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && is_empty |-> front_value == '0 && back_value == '0)
		else $error("empty queue shows data");

	// a rejected push only happens when full
	a_full_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && error == ERR_FULL |-> is_full)
		else $error("full error while not full");

	// a rejected pop only happens when empty
	a_empty_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && error == ERR_EMPTY |-> is_empty)
		else $error("empty error while not empty");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp_valid),
	.rsp_ready   (rsp_ready),
	.front_value (front_value),
	.back_value  (back_value),
	.count       (count),
	.is_empty    (is_empty),
	.is_full     (is_full),
	.error       (error)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque core testbench
// Drives command beats into double_ended_queue_core with random gaps and
// checks every result beat against a shadow ring-buffer deque: empty and full
// corner cases, pointer wrap, a long result stall, then biased random traffic.
// ----------------------------------------------------------------------------
module testbench;
	import deq_pkg::*;

	localparam int CAPACITY    = 16;
	localparam int DATA_WIDTH  = 32;
	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;

	// command codes the core treats as no-ops
	localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

	typedef struct packed {
		logic [PORT_W-1:0] front_value;
		logic [PORT_W-1:0] back_value;
		logic [PORT_W-1:0] read_value;
		logic [CNT_W-1:0]  count;
		logic              is_empty;
		logic              is_full;
		logic [ERR_W-1:0]  error;
	} deq_result_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cmd_valid = 1'b0;
	logic              cmd_ready;
	logic [CMD_W-1:0]  cmd       = CMD_PUSH_BACK;
	logic [PORT_W-1:0] value     = '0;
	logic [POS_W-1:0]  position  = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	logic [PORT_W-1:0] front_value;
	logic [PORT_W-1:0] back_value;
	logic [PORT_W-1:0] read_value;
	logic [CNT_W-1:0]  count;
	logic              is_empty;
	logic              is_full;
	logic [ERR_W-1:0]  error;

	// shadow copy of the deque contents
	logic [DATA_WIDTH-1:0] shadow_slot [CAPACITY];
	logic [3:0]            shadow_head = '0;
	logic [3:0]            shadow_tail = '0;
	logic [CNT_W-1:0]      shadow_fill = '0;

	deq_result_t rsp_expected [$];
	deq_result_t rsp_oldest;
	int          mismatches  = 0;
	int          idle_cycles = 0;
	bit          idle_on     = 1'b1;
	bit          hold_rsp    = 1'b0;

	double_ended_queue_core #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.value       (value),
		.position    (position),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.front_value (front_value),
		.back_value  (back_value),
		.read_value  (read_value),
		.count       (count),
		.is_empty    (is_empty),
		.is_full     (is_full),
		.error       (error)
	);

	always #5 clk = ~clk;

	// apply one command to the shadow deque and return the result it should give
	function automatic deq_result_t deque_apply(logic [CMD_W-1:0] c, logic [PORT_W-1:0] v,
			logic [POS_W-1:0] p);
		deq_result_t r;
		logic [3:0]  idx;
		logic [3:0]  last;
		r = '0;
		case (c)
			CMD_PUSH_BACK: begin
				if (shadow_fill == CAPACITY) begin
					r.error = ERR_FULL;
				end else begin
					shadow_slot[shadow_tail] = v;
					shadow_tail++;
					shadow_fill++;
				end
			end
			CMD_PUSH_FRONT: begin
				if (shadow_fill == CAPACITY) begin
					r.error = ERR_FULL;
				end else begin
					shadow_head--;
					shadow_slot[shadow_head] = v;
					shadow_fill++;
				end
			end
			CMD_POP_BACK: begin
				if (shadow_fill == 0) begin
					r.error = ERR_EMPTY;
				end else begin
					shadow_tail--;
					shadow_fill--;
				end
			end
			CMD_POP_FRONT: begin
				if (shadow_fill == 0) begin
					r.error = ERR_EMPTY;
				end else begin
					shadow_head++;
					shadow_fill--;
				end
			end
			CMD_READ: begin
				if (p >= shadow_fill) begin
					r.error = ERR_RANGE;
				end else begin
					idx = shadow_head + p;
					r.read_value = shadow_slot[idx];
				end
			end
			CMD_CLEAR: begin
				shadow_head = '0;
				shadow_tail = '0;
				shadow_fill = '0;
			end
			default: ;
		endcase
		if (shadow_fill != 0) begin
			last = shadow_tail - 4'd1;
			r.front_value = shadow_slot[shadow_head];
			r.back_value  = shadow_slot[last];
		end
		r.count    = shadow_fill;
		r.is_empty = (shadow_fill == 0);
		r.is_full  = (shadow_fill == CAPACITY);
		return r;
	endfunction

	// offer one command beat after a random gap; record its result once taken
	task automatic send_beat(input logic [CMD_W-1:0] c, input logic [PORT_W-1:0] v,
			input logic [POS_W-1:0] p);
		int gap;
		gap = idle_on ? $urandom_range(0, 8) : 0;
		repeat (gap) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
		end
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd       <= c;
		value     <= v;
		position  <= p;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		rsp_expected.insert(rsp_expected.size(), deque_apply(c, v, p));
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch on %s: expected %h, got %h", name, exp_v, act_v);
		end
	endtask

	// corner cases on an empty deque
	task automatic test_empty_deque();
		send_beat(CMD_POP_FRONT, 32'h0, 4'd0);
		send_beat(CMD_READ, 32'hFFFF_FFFF, 4'd0);
		send_beat(CMD_RSVD6, 32'hA5A5_5A5A, 4'd15);
	endtask

	// fill from both ends across the wrap point, then hit the full and range limits
	task automatic test_full_and_wrap();
		logic [PORT_W-1:0] v;
		for (int k = 0; k < CAPACITY; k++) begin
			v = (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFF_FFFF : $urandom;
			send_beat((k % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, v, 4'(k));
		end
		send_beat(CMD_PUSH_BACK, 32'h1234_5678, 4'd0);
		send_beat(CMD_PUSH_FRONT, 32'h8765_4321, 4'd0);
		send_beat(CMD_READ, 32'h0, 4'd15);
		send_beat(CMD_POP_BACK, 32'h0, 4'd0);
		send_beat(CMD_READ, 32'h0, 4'd14);
		send_beat(CMD_CLEAR, 32'h0, 4'd0);
		send_beat(CMD_POP_BACK, 32'h0, 4'd0);
		send_beat(CMD_RSVD7, 32'hFFFF_FFFF, 4'd7);
	endtask

	// stall results for a long stretch while commands are offered back to back
	task automatic test_result_stall();
		idle_on  = 1'b0;
		hold_rsp = 1'b1;
		for (int k = 0; k < 24; k++)
			send_beat((k % 3 == 2) ? CMD_READ : CMD_PUSH_BACK, $urandom, 4'(k));
		idle_on = 1'b1;
	endtask

	// random traffic in chunks, each biased toward filling, draining or reading
	task automatic test_random_traffic(input int n);
		int                mode;
		int                roll;
		int                push_lim;
		int                pop_lim;
		int                vsel;
		logic [CMD_W-1:0]  c;
		logic [PORT_W-1:0] v;
		logic [POS_W-1:0]  p;
		mode     = 0;
		push_lim = 50;
		pop_lim  = 75;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) begin
				mode    = $urandom_range(0, 3);
				idle_on = ($urandom_range(0, 3) != 0);
				case (mode)
					0: begin push_lim = 70; pop_lim = 85; end
					1: begin push_lim = 35; pop_lim = 85; end
					2: begin push_lim = 45; pop_lim = 65; end
					default: begin push_lim = 50; pop_lim = 75; end
				endcase
			end
			roll = $urandom_range(0, 99);
			if (roll < 2)
				c = CMD_CLEAR;
			else if (roll == 2)
				c = CMD_RSVD6;
			else if (roll == 3)
				c = CMD_RSVD7;
			else if (roll < push_lim)
				c = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
			else if (roll < pop_lim)
				c = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
			else
				c = CMD_READ;
			vsel = $urandom_range(0, 9);
			v = (vsel == 0) ? 32'h0 : (vsel == 1) ? 32'hFFFF_FFFF : $urandom;
			if (c == CMD_READ && shadow_fill != 0 && $urandom_range(0, 3) != 0)
				p = POS_W'($urandom_range(0, shadow_fill - 1));
			else
				p = POS_W'($urandom_range(0, 15));
			send_beat(c, v, p);
		end
	endtask

	// compare every result beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsp_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result beat with nothing expected: count %0d error %0d",
						count, error);
			end else begin
				rsp_oldest = rsp_expected[0];
				rsp_expected.delete(0);
				check_field("front_value", rsp_oldest.front_value, front_value);
				check_field("back_value", rsp_oldest.back_value, back_value);
				check_field("read_value", rsp_oldest.read_value, read_value);
				check_field("count", 32'(rsp_oldest.count), 32'(count));
				check_field("is_empty", 32'(rsp_oldest.is_empty), 32'(is_empty));
				check_field("is_full", 32'(rsp_oldest.is_full), 32'(is_full));
				check_field("error", 32'(rsp_oldest.error), 32'(error));
			end
		end
	end

	// result sink: random stalls, plus one long hold when asked
	initial begin : rsp_sink
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_rsp) begin
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					rsp_ready <= 1'b0;
				end
				hold_rsp = 1'b0;
			end
			stall = idle_on ? $urandom_range(0, 8) : 0;
			repeat (stall) begin
				@(negedge clk);
				rsp_ready <= 1'b0;
			end
			@(negedge clk);
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	// watchdog: too long without any beat on either channel
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("no beat for %0d cycles", STALL_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_deque();
		test_full_and_wrap();
		test_result_stall();
		test_random_traffic(1700);

		@(negedge clk);
		cmd_valid <= 1'b0;
		while (rsp_expected.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
